// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the frame checker.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every sampled edge outside reset.
`define DPFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define DPFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/dpfc_pkg.sv
// Package of the packet frame checker: marker bytes, phase and status codes,
// and the hex digit decoder. No dependencies.
package dpfc_pkg;

	localparam logic [7:0] CH_START     = 8'h24;
	localparam logic [7:0] CH_END       = 8'h23;
	localparam logic [7:0] ESCAPE_RESET = 8'h7D;
	localparam logic [2:0] LEN_MIN      = 3'd4;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_PAYLOAD = 3'd1,
		PH_SUM0    = 3'd2,
		PH_SUM1    = 3'd3,
		PH_SUM2    = 3'd4,
		PH_SUMMORE = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_NO_START = 3'd2,
		ST_SHORT    = 3'd3,
		ST_NO_END   = 3'd4,
		ST_SUM_LEN  = 3'd5,
		ST_BAD_HEX  = 3'd6,
		ST_MISMATCH = 3'd7
	} status_t;

	// Returns the digit value in the low four bits; bit 4 flags a non-hex byte.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		if (c >= 8'h61 && c <= 8'h66) begin
			v = {1'b0, c[3:0] + 4'd9};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, c[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = {1'b0, c[3:0] + 4'd9};
		end else begin
			v = 5'h10;
		end
		return v;
	endfunction

endpackage

// File: rtl/dpfc_in_if.sv
// Input channel of the frame checker: one received byte per word.
// Valid/ready handshake; no package dependency.
interface dpfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       byte_present;
	logic       end_of_string;

	modport source (output valid, rx_byte, byte_present, end_of_string, input ready);
	modport sink (input valid, rx_byte, byte_present, end_of_string, output ready);
endinterface

// File: rtl/dpfc_out_if.sv
// Result channel of the frame checker: payload bytes and the frame status.
// Valid/ready handshake; no package dependency.
interface dpfc_out_if;
	logic       valid;
	logic       ready;
	logic       payload_valid;
	logic [7:0] payload_byte;
	logic       frame_done;
	logic [2:0] frame_status;
	logic [7:0] computed_sum;

	modport source (output valid, payload_valid, payload_byte, frame_done, frame_status,
		computed_sum, input ready);
	modport sink (input valid, payload_valid, payload_byte, frame_done, frame_status,
		computed_sum, output ready);
endinterface

// File: rtl/debug_packet_frame_checker.sv
// Frame checker: an accepted word goes into the input stage register, and its result is
// loaded from there into the output register once that is free; one word is accepted per
// cycle while results are taken, set by the single register-to-register pass
// of the framing logic. The output register holds a waiting result while the input stage
// refills. arst_n clears the frame state and both valid flags and restores the escape
// byte to 0x7D. Depends on dpfc_pkg, dpfc_in_if, dpfc_out_if and assert_macros.svh.
`include "assert_macros.svh"

module debug_packet_frame_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       escape_char_we,
	input  logic [7:0] escape_char_wdata,
	dpfc_in_if.sink    byte_chan,
	dpfc_out_if.source result_chan
);
	import dpfc_pkg::*;

	// Configuration register.
	logic [7:0] escape_char_q;

	// Input stage: one accepted word.
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       present_s1;
	logic       last_s1;

	// Frame state.
	phase_t     phase_q;
	logic       esc_pend_q;
	logic [7:0] run_sum_q;
	logic [7:0] rcv_sum_q;
	logic       digits_good_q;
	logic [2:0] length_q;
	logic       saw_byte_q;

	// Result register.
	logic       out_valid_q;
	logic       pay_valid_q;
	logic [7:0] pay_byte_q;
	logic       done_q;
	status_t    status_q;
	logic [7:0] sum_out_q;

	// Next-state values of the framing logic for the word in the input stage.
	phase_t     phase_n;
	logic       esc_pend_n;
	logic [7:0] run_sum_n;
	logic [7:0] rcv_sum_n;
	logic       digits_good_n;
	logic [2:0] length_n;
	logic       saw_byte_n;
	logic       pay;
	status_t    status_n;
	logic [4:0] hex_v;

	logic has_result;
	logic out_free;
	logic advance_s1;
	logic frame_clear;

	// The input stage moves on when its word yields no result or the output register
	// is free (empty, or being emptied in this cycle).
	assign out_free   = !out_valid_q || result_chan.ready;
	assign has_result = pay || last_s1;
	assign advance_s1 = valid_s1 && (!has_result || out_free);
	assign byte_chan.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_char_q <= ESCAPE_RESET;
		end else if (escape_char_we) begin
			escape_char_q <= escape_char_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_chan.ready) begin
			valid_s1 <= byte_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_chan.ready && byte_chan.valid) begin
			rx_byte_s1 <= byte_chan.rx_byte;
			present_s1 <= byte_chan.byte_present;
			last_s1    <= byte_chan.end_of_string;
		end
	end

	// Framing step. Escapes are honored only while looking for the markers; inside
	// the payload an escape byte and the byte it guards are still payload.
	always_comb begin
		phase_n       = phase_q;
		esc_pend_n    = esc_pend_q;
		run_sum_n     = run_sum_q;
		rcv_sum_n     = rcv_sum_q;
		digits_good_n = digits_good_q;
		length_n      = length_q;
		saw_byte_n    = saw_byte_q;
		pay           = 1'b0;
		hex_v         = hex_value(rx_byte_s1);

		if (present_s1) begin
			saw_byte_n = 1'b1;
			if (phase_q != PH_HUNT && length_q < LEN_MIN) begin
				length_n = length_q + 3'd1;
			end
			unique case (phase_q)
				PH_PAYLOAD: begin
					if (esc_pend_q) begin
						esc_pend_n = 1'b0;
						pay        = 1'b1;
					end else if (rx_byte_s1 == escape_char_q) begin
						esc_pend_n = 1'b1;
						pay        = 1'b1;
					end else if (rx_byte_s1 == CH_END) begin
						phase_n = PH_SUM0;
					end else begin
						pay = 1'b1;
					end
					if (pay) begin
						run_sum_n = run_sum_q + rx_byte_s1;
					end
				end
				PH_SUM0, PH_SUM1: begin
					if (hex_v[4]) begin
						digits_good_n = 1'b0;
					end
					rcv_sum_n = {rcv_sum_q[3:0], hex_v[3:0]};
					phase_n   = (phase_q == PH_SUM0) ? PH_SUM1 : PH_SUM2;
				end
				PH_SUM2, PH_SUMMORE: begin
					// Extra bytes only mark a wrong checksum length.
					phase_n = PH_SUMMORE;
				end
				default: begin
					// Hunting for the start marker.
					if (esc_pend_q) begin
						esc_pend_n = 1'b0;
					end else if (rx_byte_s1 == escape_char_q) begin
						esc_pend_n = 1'b1;
					end else if (rx_byte_s1 == CH_START) begin
						phase_n    = PH_PAYLOAD;
						esc_pend_n = 1'b0;
						length_n   = 3'd1;
					end
				end
			endcase
		end

		// The first failing check in this order decides the status.
		if (!saw_byte_n) begin
			status_n = ST_EMPTY;
		end else if (phase_n == PH_HUNT) begin
			status_n = ST_NO_START;
		end else if (length_n < LEN_MIN) begin
			status_n = ST_SHORT;
		end else if (phase_n == PH_PAYLOAD) begin
			status_n = ST_NO_END;
		end else if (phase_n != PH_SUM2) begin
			status_n = ST_SUM_LEN;
		end else if (!digits_good_n) begin
			status_n = ST_BAD_HEX;
		end else if (rcv_sum_n != run_sum_n) begin
			status_n = ST_MISMATCH;
		end else begin
			status_n = ST_OK;
		end
	end

	// Frame state; the closing word returns everything but the escape byte to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			esc_pend_q    <= 1'b0;
			run_sum_q     <= 8'd0;
			rcv_sum_q     <= 8'd0;
			digits_good_q <= 1'b1;
			length_q      <= 3'd0;
			saw_byte_q    <= 1'b0;
		end else if (advance_s1) begin
			if (last_s1) begin
				phase_q       <= PH_HUNT;
				esc_pend_q    <= 1'b0;
				run_sum_q     <= 8'd0;
				rcv_sum_q     <= 8'd0;
				digits_good_q <= 1'b1;
				length_q      <= 3'd0;
				saw_byte_q    <= 1'b0;
			end else begin
				phase_q       <= phase_n;
				esc_pend_q    <= esc_pend_n;
				run_sum_q     <= run_sum_n;
				rcv_sum_q     <= rcv_sum_n;
				digits_good_q <= digits_good_n;
				length_q      <= length_n;
				saw_byte_q    <= saw_byte_n;
			end
		end
	end

	// Output register: loaded when a result leaves the input stage, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && has_result) begin
			out_valid_q <= 1'b1;
		end else if (result_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && has_result) begin
			pay_valid_q <= pay;
			pay_byte_q  <= pay ? rx_byte_s1 : 8'd0;
			done_q      <= last_s1;
			status_q    <= last_s1 ? status_n : ST_OK;
			sum_out_q   <= run_sum_n;
		end
	end

	assign result_chan.valid         = out_valid_q;
	assign result_chan.payload_valid = pay_valid_q;
	assign result_chan.payload_byte  = pay_byte_q;
	assign result_chan.frame_done    = done_q;
	assign result_chan.frame_status  = status_q;
	assign result_chan.computed_sum  = sum_out_q;

	// Frame state as it stands right after reset.
	assign frame_clear = phase_q == PH_HUNT && run_sum_q == 8'd0 && !saw_byte_q;

	// A result that does not close the string reports the ok code.
	`DPFC_ASSERT(a_status_only_done, !out_valid_q || done_q || status_q == ST_OK, "stray status")
	// The byte count from the start marker saturates at the minimum frame length.
	`DPFC_ASSERT(a_length_sat, length_q <= LEN_MIN, "length counter ran past saturation")
	// Once past the start marker the count includes at least the marker itself.
	`DPFC_ASSERT(a_len_after_start, phase_q == PH_HUNT || (|length_q && saw_byte_q), "bad start")
	// The closing word leaves the frame state at reset.
	`DPFC_ASSERT_NEXT(a_clear_on_close, advance_s1 && last_s1, frame_clear, "frame not cleared")
	// A waiting result stays in the output register while the receiver does not take it.
	`DPFC_ASSERT_NEXT(a_no_overwrite, !out_free, out_valid_q, "waiting result dropped")

endmodule

// File: tb/debug_packet_frame_checker_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the debug packet frame checker: a frame predictor
// scores every result word against words the block accepted. Depends on dpfc_pkg,
// dpfc_in_if, dpfc_out_if and the frame checker RTL.
module debug_packet_frame_checker_test;
	import dpfc_pkg::*;

	// A window this long with no word moving on either channel means the block hung.
	localparam int WATCHDOG_LIMIT = 3000;
	// Lets words that yield no result drain from the input stage after the last result.
	localparam int SETTLE_CYCLES = 8;
	// Counted words per random phase; six phases give at least 360 words.
	localparam int PHASE_WORDS = 60;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       byte_present;
		logic       end_of_string;
	} rx_word_t;

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       frame_done;
		status_t    frame_status;
		logic [7:0] computed_sum;
	} frame_result_t;

	// Tracks the framing of the string in flight and queues the result word that each
	// accepted input word should produce, then scores the block's result words.
	class frame_tracker;
		logic [7:0]    esc_byte;
		phase_t        phase;
		logic          esc_pending;
		logic          saw_byte;
		logic          digits_ok;
		logic [7:0]    payload_sum;
		logic [7:0]    sent_sum;
		logic [2:0]    len_count;
		frame_result_t pending_results[$];
		int            fail_count;
		int            results_seen;
		int            status_seen[8];

		function new();
			esc_byte = ESCAPE_RESET;
			fail_count = 0;
			results_seen = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			phase = PH_HUNT;
			esc_pending = 1'b0;
			saw_byte = 1'b0;
			digits_ok = 1'b1;
			payload_sum = 8'h00;
			sent_sum = 8'h00;
			len_count = 3'd0;
		endfunction

		function void note_word(rx_word_t w);
			frame_result_t r;
			logic          pay;
			logic [4:0]    digit;
			pay = 1'b0;
			r = '0;
			if (w.byte_present) begin
				saw_byte = 1'b1;
				if (phase != PH_HUNT && len_count < LEN_MIN) len_count = len_count + 3'd1;
				case (phase)
					PH_HUNT: begin
						if (esc_pending) begin
							esc_pending = 1'b0;
						end else if (w.rx_byte == esc_byte) begin
							esc_pending = 1'b1;
						end else if (w.rx_byte == CH_START) begin
							phase = PH_PAYLOAD;
							len_count = 3'd1;
						end
					end
					PH_PAYLOAD: begin
						// Escapes only hide markers; the escape byte itself is payload.
						if (esc_pending) begin
							esc_pending = 1'b0;
							pay = 1'b1;
						end else if (w.rx_byte == esc_byte) begin
							esc_pending = 1'b1;
							pay = 1'b1;
						end else if (w.rx_byte == CH_END) begin
							phase = PH_SUM0;
						end else begin
							pay = 1'b1;
						end
						if (pay) payload_sum = payload_sum + w.rx_byte;
					end
					PH_SUM0, PH_SUM1: begin
						digit = 5'h10;
						if (w.rx_byte >= "0" && w.rx_byte <= "9") digit = 5'(w.rx_byte - "0");
						else if (w.rx_byte >= "a" && w.rx_byte <= "f") digit = 5'(w.rx_byte - "a" + 10);
						else if (w.rx_byte >= "A" && w.rx_byte <= "F") digit = 5'(w.rx_byte - "A" + 10);
						if (digit[4]) digits_ok = 1'b0;
						sent_sum = {sent_sum[3:0], digit[3:0]};
						phase = phase_t'(phase + 3'd1);
					end
					default: begin
						phase = PH_SUMMORE;
					end
				endcase
			end
			if (!pay && !w.end_of_string) return;
			r.payload_valid = pay;
			r.payload_byte = pay ? w.rx_byte : 8'h00;
			r.frame_done = w.end_of_string;
			r.frame_status = ST_OK;
			r.computed_sum = payload_sum;
			if (w.end_of_string) begin
				if (!saw_byte) r.frame_status = ST_EMPTY;
				else if (phase == PH_HUNT) r.frame_status = ST_NO_START;
				else if (len_count < LEN_MIN) r.frame_status = ST_SHORT;
				else if (phase == PH_PAYLOAD) r.frame_status = ST_NO_END;
				else if (phase != PH_SUM2) r.frame_status = ST_SUM_LEN;
				else if (!digits_ok) r.frame_status = ST_BAD_HEX;
				else if (sent_sum != payload_sum) r.frame_status = ST_MISMATCH;
				clear_frame();
			end
			pending_results.push_back(r);
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word %h with nothing predicted", $time, got);
				fail_count++;
				return;
			end
			want = pending_results.pop_front();
			if (want.frame_done) status_seen[want.frame_status]++;
			if (got.payload_valid !== want.payload_valid) begin
				$display("%0t: payload_valid expected %b got %b", $time,
					want.payload_valid, got.payload_valid);
				fail_count++;
			end
			if (got.payload_byte !== want.payload_byte) begin
				$display("%0t: payload_byte expected %h got %h", $time,
					want.payload_byte, got.payload_byte);
				fail_count++;
			end
			if (got.frame_done !== want.frame_done) begin
				$display("%0t: frame_done expected %b got %b", $time,
					want.frame_done, got.frame_done);
				fail_count++;
			end
			if (got.frame_status !== want.frame_status) begin
				$display("%0t: frame_status expected %0d got %0d", $time,
					want.frame_status, got.frame_status);
				fail_count++;
			end
			if (got.computed_sum !== want.computed_sum) begin
				$display("%0t: computed_sum expected %h got %h", $time,
					want.computed_sum, got.computed_sum);
				fail_count++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       escape_char_we;
	logic [7:0] escape_char_wdata;

	dpfc_in_if  byte_chan ();
	dpfc_out_if result_chan ();

	frame_tracker tracker;

	// Stimulus bookkeeping. Ignored words (no byte, not closing) are kept out of words_sent.
	logic [7:0] frame_bytes[$];
	bit         close_on_empty;
	int         tx_idle_pct;
	int         rx_stall_pct;
	int         words_sent;
	int         ignored_words;
	int         frames_sent;
	int         escape_settings;
	int         idle_cycles;

	debug_packet_frame_checker uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.escape_char_we   (escape_char_we),
		.escape_char_wdata(escape_char_wdata),
		.byte_chan        (byte_chan),
		.result_chan      (result_chan)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Both channels are sampled at the rising edge, where every input the testbench
	// drives is stable: after their initial values they change through nonblocking assignments only.
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_chan.valid && byte_chan.ready) begin
				tracker.note_word({byte_chan.rx_byte, byte_chan.byte_present,
					byte_chan.end_of_string});
			end
			if (result_chan.valid && result_chan.ready) begin
				tracker.check_result({result_chan.payload_valid, result_chan.payload_byte,
					result_chan.frame_done, status_t'(result_chan.frame_status),
					result_chan.computed_sum});
			end
		end
	end

	// The receiver stalls at random; a stall rate of zero keeps ready high throughout.
	always @(posedge clk) begin
		result_chan.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// Watchdog: any accepted word on either side restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (byte_chan.valid && byte_chan.ready)
			|| (result_chan.valid && result_chan.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles, %0d results still due", $time,
				WATCHDOG_LIMIT, tracker.pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offers one word and returns at the edge where it is accepted. valid stays high
	// on return so back-to-back words never drop it; the sender may first idle.
	task automatic send_word(input logic [7:0] b, input logic present, input logic last);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			byte_chan.valid <= 1'b0;
			@(posedge clk);
		end
		byte_chan.valid <= 1'b1;
		byte_chan.rx_byte <= b;
		byte_chan.byte_present <= present;
		byte_chan.end_of_string <= last;
		@(posedge clk);
		while (!byte_chan.ready) @(posedge clk);
		if (present || last) words_sent++;
		else ignored_words++;
	endtask

	// Sends frame_bytes as one string. The string closes on its last byte, or on a
	// closing word with no byte; now and then a word with no byte is slipped in.
	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++) begin
			if ($urandom_range(0, 19) == 0) send_word(8'($urandom), 1'b0, 1'b0);
			send_word(frame_bytes[i], 1'b1, !close_on_empty && i == frame_bytes.size() - 1);
		end
		if (close_on_empty || frame_bytes.size() == 0) send_word(8'($urandom), 1'b0, 1'b1);
		frames_sent++;
	endtask

	task automatic send_text(input string s, input bit close);
		frame_bytes.delete();
		for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
		close_on_empty = close;
		send_frame();
	endtask

	function automatic logic [7:0] nibble_char(input logic [3:0] nib);
		if (nib < 4'd10) return "0" + nib;
		return (($urandom_range(0, 1) == 1) ? "A" : "a") + nib - 8'd10;
	endfunction

	// Builds one random string. Most are good frames with random payload, escapes
	// and digit case; the rest are broken in one way or are plain noise.
	task automatic build_frame();
		logic [7:0] esc;
		logic [7:0] c;
		logic [7:0] sum;
		logic [7:0] hi;
		logic [7:0] lo;
		int         flaw;
		int         n;
		esc = tracker.esc_byte;
		frame_bytes.delete();
		close_on_empty = ($urandom_range(0, 9) == 0);
		flaw = ($urandom_range(0, 99) < 70) ? -1 : $urandom_range(0, 7);
		if (flaw == 5) begin
			// Pure noise, possibly nothing at all.
			n = $urandom_range(0, 10);
			repeat (n) frame_bytes.push_back(8'($urandom));
			return;
		end
		// Leading garbage before the start marker.
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				c = 8'($urandom);
				frame_bytes.push_back((c == CH_START) ? 8'h2A : c);
			end
		end
		// Flaw 6 drops the start marker.
		if (flaw != 6) frame_bytes.push_back(CH_START);
		if (flaw == 7) begin
			// Too short to hold a marker pair and two digits.
			if ($urandom_range(0, 1) == 1) frame_bytes.push_back(8'($urandom));
			return;
		end
		sum = 8'h00;
		repeat ($urandom_range(0, 12)) begin
			c = ($urandom_range(0, 7) == 0) ? esc : 8'($urandom);
			if (c == esc) begin
				// An escape and the byte it covers both count as payload.
				frame_bytes.push_back(c);
				sum = sum + c;
				c = ($urandom_range(0, 2) == 0) ? CH_END : 8'($urandom);
			end else if (c == CH_END) begin
				c = 8'h2E;
			end
			frame_bytes.push_back(c);
			sum = sum + c;
		end
		// Flaw 0 leaves the end marker and the digits out.
		if (flaw == 0) return;
		frame_bytes.push_back(CH_END);
		if (flaw == 1) sum = sum ^ 8'($urandom_range(1, 255));
		hi = nibble_char(sum[7:4]);
		lo = nibble_char(sum[3:0]);
		if (flaw == 2) begin
			if ($urandom_range(0, 1) == 1) hi = 8'($urandom);
			else lo = 8'($urandom);
		end
		frame_bytes.push_back(hi);
		if (flaw != 3) frame_bytes.push_back(lo);
		if (flaw == 4) repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
	endtask

	// Holds the sender off until every predicted result has come back, then lets the
	// pipeline empty of words that produce no result.
	task automatic settle_block();
		byte_chan.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_escape(input logic [7:0] v);
		escape_char_we <= 1'b1;
		escape_char_wdata <= v;
		@(posedge clk);
		escape_char_we <= 1'b0;
		tracker.esc_byte = v;
		escape_settings++;
	endtask

	initial begin
		int phase_start;
		tracker = new();
		arst_n = 1'b0;
		escape_char_we = 1'b0;
		escape_char_wdata = 8'h00;
		byte_chan.valid = 1'b0;
		byte_chan.rx_byte = 8'h00;
		byte_chan.byte_present = 1'b0;
		byte_chan.end_of_string = 1'b0;
		tx_idle_pct = 30;
		rx_stall_pct = 49;
		words_sent = 0;
		ignored_words = 0;
		frames_sent = 0;
		escape_settings = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings at the reset escape byte '}'.
		// A closing word with no byte at all is an empty string.
		send_text("", 1'b1);
		// The escape byte hides the only start marker.
		send_text("}$", 1'b0);
		// Start, end and one digit: too short.
		send_text("$#0", 1'b0);
		// An escaped end marker stays payload, so the frame never ends. A word with no
		// byte in the middle of the payload must change nothing.
		send_word(CH_START, 1'b1, 1'b0);
		send_word("a", 1'b1, 1'b0);
		send_word(8'hFF, 1'b0, 1'b0);
		send_word(ESCAPE_RESET, 1'b1, 1'b0);
		send_word(CH_END, 1'b1, 1'b1);
		// Top byte value as payload, checksum in mixed case: good frame.
		send_text("$\377#Ff", 1'b0);
		// Non-hex second digit.
		send_text("$#0g", 1'b0);
		// A third checksum digit.
		send_text("$#000", 1'b0);

		// Random phases: each writes a new escape byte while the block is idle, the
		// extremes and both marker values among them, and the idling pattern moves
		// from sender-light to receiver-light to none at all.
		for (int p = 0; p < 6; p++) begin
			settle_block();
			case (p)
				0: write_escape(8'h00);
				1: write_escape(8'hFF);
				2: write_escape(CH_START);
				3: write_escape(8'($urandom));
				4: write_escape(CH_END);
				default: write_escape(ESCAPE_RESET);
			endcase
			if (p < 2) begin
				tx_idle_pct = 30;
				rx_stall_pct = 49;
			end else if (p < 4) begin
				tx_idle_pct = 49;
				rx_stall_pct = 30;
			end else begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS) begin
				build_frame();
				send_frame();
				if ($urandom_range(0, 39) == 0) settle_block();
			end
		end
		settle_block();

		$display("Covered %0d strings, %0d words (%0d ignored words besides),",
			frames_sent, words_sent, ignored_words);
		$display("%0d results and %0d escape settings.",
			tracker.results_seen, escape_settings);
		$display("Closing status counts, ok to mismatch: %0d %0d %0d %0d %0d %0d %0d %0d",
			tracker.status_seen[0], tracker.status_seen[1], tracker.status_seen[2],
			tracker.status_seen[3], tracker.status_seen[4], tracker.status_seen[5],
			tracker.status_seen[6], tracker.status_seen[7]);
		if (tracker.fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
